/* sv/bse_pkg.sv */
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types, sizes and register codes of the bucket sort engine.
// ----------------------------------------------------------------------------
package bse_pkg;

  // Sizes
  localparam int MAX_ITEMS   = 64;
  localparam int MAX_BUCKETS = 16;
  localparam int BKT_W       = $clog2(MAX_BUCKETS);
  localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
  localparam int VAL_W       = 32;
  localparam int WID_W       = 31;
  localparam int BCNT_W      = 5;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUCKET_COUNT = 2'd0,
    CFG_MIN_VALUE    = 2'd1,
    CFG_BUCKET_WIDTH = 2'd2
  } cfg_idx_e;

  // Input request payload
  typedef struct packed {
    logic signed [VAL_W-1:0] item_value;
    logic                    item_last;
  } item_t;

  // Result payload
  typedef struct packed {
    logic signed [VAL_W-1:0] sorted_value;
    logic                    sorted_last;
    logic                    items_dropped;
  } result_t;

  // Configuration registers as seen by the bucket pipeline
  typedef struct packed {
    logic [BCNT_W-1:0]       bucket_count;
    logic signed [VAL_W-1:0] min_value;
    logic [WID_W-1:0]        bucket_width;
  } cfg_t;

  // Sort key: bucket first, then value
  typedef struct packed {
    logic [BKT_W-1:0]        bkt;
    logic signed [VAL_W-1:0] value;
  } key_t;

  // One slot of the insertion chain
  typedef struct packed {
    logic valid;
    key_t key;
  } cell_t;

  // Chain control, common to every cell
  typedef struct packed {
    logic ins_en;
    logic shift_en;
  } cell_ctrl_t;

  // Side band that travels with a value through the bucket pipeline
  typedef struct packed {
    logic valid;
    logic keep;
    logic last;
  } pipe_ctrl_t;

  // a goes strictly after b
  function automatic logic key_gt(key_t a, key_t b);
    logic bkt_gt;
    logic bkt_eq;
    bkt_gt = a.bkt > b.bkt;
    bkt_eq = a.bkt == b.bkt;
    return bkt_gt || (bkt_eq && ($signed(a.value) > $signed(b.value)));
  endfunction

endpackage

/* sv/bse_bucket_pipe.sv */
// ----------------------------------------------------------------------------
// bse_bucket_pipe
// Pipelined bucket index: (value - min) / width, clamped to the bucket range.
// One quotient bit per stage; anything of sixteen widths or more saturates.
// ----------------------------------------------------------------------------
module bse_bucket_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bse_pkg::cfg_t      cfg_i,
  input  bse_pkg::pipe_ctrl_t in_ctrl_i,
  input  bse_pkg::item_t     in_item_i,
  output bse_pkg::pipe_ctrl_t out_ctrl_o,
  output bse_pkg::key_t      out_key_o
);
  import bse_pkg::*;

  localparam int NSTG  = BKT_W + 2;
  localparam int REM_W = VAL_W + 1;
  localparam int CMP_W = VAL_W + BKT_W;

  typedef struct packed {
    pipe_ctrl_t              ctrl;
    logic signed [VAL_W-1:0] value;
    logic [REM_W-1:0]        rem;
    logic                    sat;
    logic [BKT_W-1:0]        quo;
  } stage_t;

  stage_t st_q [NSTG];
  stage_t st_d [NSTG];

  logic [WID_W-1:0]  w_eff;
  logic [BCNT_W-1:0] n_sat;
  logic [BKT_W-1:0]  top_bkt;
  logic [BKT_W-1:0]  idx;
  logic              neg;

  // Effective width and bucket count
  always_comb begin
    w_eff = (cfg_i.bucket_width == '0) ? WID_W'(1) : cfg_i.bucket_width;
    if (cfg_i.bucket_count == '0) begin
      n_sat = BCNT_W'(1);
    end else if (cfg_i.bucket_count > BCNT_W'(MAX_BUCKETS)) begin
      n_sat = BCNT_W'(MAX_BUCKETS);
    end else begin
      n_sat = cfg_i.bucket_count;
    end
    top_bkt = BKT_W'(n_sat - BCNT_W'(1));
  end

  // Stage logic
  always_comb begin
    // offset from the base of bucket zero
    st_d[0].ctrl  = in_ctrl_i;
    st_d[0].value = in_item_i.item_value;
    st_d[0].rem   = {in_item_i.item_value[VAL_W-1], in_item_i.item_value}
                  - {cfg_i.min_value[VAL_W-1], cfg_i.min_value};
    st_d[0].sat   = 1'b0;
    st_d[0].quo   = '0;

    // below the base goes to bucket zero; past sixteen widths saturates
    neg           = st_q[0].rem[REM_W-1];
    st_d[1]       = st_q[0];
    st_d[1].rem   = neg ? '0 : st_q[0].rem;
    st_d[1].sat   = !neg && (CMP_W'(st_q[0].rem[VAL_W-1:0]) >= (CMP_W'(w_eff) << BKT_W));

    // restoring division, most significant quotient bit first
    for (int s = 0; s < BKT_W; s++) begin
      st_d[s+2] = st_q[s+1];
      if (CMP_W'(st_q[s+1].rem[VAL_W-1:0]) >= (CMP_W'(w_eff) << (BKT_W-1-s))) begin
        st_d[s+2].rem = st_q[s+1].rem - REM_W'(CMP_W'(w_eff) << (BKT_W-1-s));
        st_d[s+2].quo[BKT_W-1-s] = 1'b1;
      end
    end
  end

  // Stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NSTG; s++) begin
        st_q[s] <= '0;
      end
    end else begin
      st_q <= st_d;
    end
  end

  // Clamp to the last bucket in use
  always_comb begin
    idx = st_q[NSTG-1].sat ? '1 : st_q[NSTG-1].quo;
    out_key_o.bkt   = (idx > top_bkt) ? top_bkt : idx;
    out_key_o.value = st_q[NSTG-1].value;
    out_ctrl_o      = st_q[NSTG-1].ctrl;
  end

endmodule

/* sv/bse_cell.sv */
// ----------------------------------------------------------------------------
// bse_cell
// One slot of the insertion chain. Holds a key, makes room for a smaller
// arriving key by taking its left neighbour, and shifts left when draining.
// ----------------------------------------------------------------------------
module bse_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bse_pkg::cell_ctrl_t ctrl_i,
  input  bse_pkg::key_t       ins_key_i,
  input  logic                prev_gt_i,
  input  bse_pkg::cell_t      prev_i,
  input  bse_pkg::cell_t      next_i,
  output bse_pkg::cell_t      cell_o,
  output logic                gt_o
);
  import bse_pkg::*;

  cell_t cell_q;
  cell_t cell_d;

  // empty slots count as larger than anything
  assign gt_o = !cell_q.valid || key_gt(cell_q.key, ins_key_i);

  // Next slot contents
  always_comb begin
    cell_d = cell_q;
    if (ctrl_i.shift_en) begin
      cell_d = next_i;
    end else if (ctrl_i.ins_en && gt_o) begin
      if (prev_gt_i) begin
        cell_d = prev_i;
      end else begin
        cell_d.valid = 1'b1;
        cell_d.key   = ins_key_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

/* sv/bse_sort_chain.sv */
// ----------------------------------------------------------------------------
// bse_sort_chain
// Row of insertion cells kept in ascending key order, smallest at the head.
// ----------------------------------------------------------------------------
module bse_sort_chain (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bse_pkg::cell_ctrl_t ctrl_i,
  input  bse_pkg::key_t       ins_key_i,
  output bse_pkg::cell_t      head_o
);
  import bse_pkg::*;

  cell_t cells [MAX_ITEMS];
  logic  gts   [MAX_ITEMS];

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    cell_t prev_c;
    cell_t next_c;
    logic  prev_gt;

    // neighbour wiring; the ends see an empty slot
    if (i == 0) begin : g_first
      assign prev_c  = '0;
      assign prev_gt = 1'b0;
    end else begin : g_mid
      assign prev_c  = cells[i-1];
      assign prev_gt = gts[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_last
      assign next_c = '0;
    end else begin : g_inner
      assign next_c = cells[i+1];
    end

    bse_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl_i),
      .ins_key_i (ins_key_i),
      .prev_gt_i (prev_gt),
      .prev_i    (prev_c),
      .next_i    (next_c),
      .cell_o    (cells[i]),
      .gt_o      (gts[i])
    );
  end

  assign head_o = cells[0];

endmodule

/* sv/bucket_sort_engine.sv */
// ----------------------------------------------------------------------------
// bucket_sort_engine
// Loading: one request per cycle; each value passes the bucket pipeline registers
// before it reaches the chain. Once the last request has reached the chain, results
// come out one per cycle while the output is not stalled; a new set is taken
// the cycle after the final result leaves the chain.
// Reset empties the chain and restores bucket_count 10, min 0, width 1.
// ----------------------------------------------------------------------------
module bucket_sort_engine (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  bse_pkg::item_t                       in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output bse_pkg::result_t                     out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [bse_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [bse_pkg::VAL_W-1:0]            cfg_wdata_i
);
  import bse_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e     state_q;
  logic [CNT_W-1:0] cnt_q;
  logic       ovf_q;
  logic       out_valid_q;
  result_t    out_q;
  cfg_t       cfg_q;

  logic       in_fire;
  logic       keep;
  logic       pop;
  pipe_ctrl_t pin_ctrl;
  pipe_ctrl_t pout_ctrl;
  key_t       pout_key;
  cell_ctrl_t chain_ctrl;
  cell_t      head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bucket_count <= BCNT_W'(10);
      cfg_q.min_value    <= '0;
      cfg_q.bucket_width <= WID_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BUCKET_COUNT: cfg_q.bucket_count <= cfg_wdata_i[BCNT_W-1:0];
        CFG_MIN_VALUE:    cfg_q.min_value    <= cfg_wdata_i;
        CFG_BUCKET_WIDTH: cfg_q.bucket_width <= cfg_wdata_i[WID_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshakes and chain control
  assign in_ready_o = (state_q == ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign keep       = cnt_q < CNT_W'(MAX_ITEMS);
  assign pop        = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    pin_ctrl.valid      = in_fire;
    pin_ctrl.keep       = keep;
    pin_ctrl.last       = in_data_i.item_last;
    chain_ctrl.ins_en   = pout_ctrl.valid && pout_ctrl.keep;
    chain_ctrl.shift_en = pop;
  end

  bse_bucket_pipe u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_ctrl_i  (pin_ctrl),
    .in_item_i  (in_data_i),
    .out_ctrl_o (pout_ctrl),
    .out_key_o  (pout_key)
  );

  bse_sort_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (chain_ctrl),
    .ins_key_i (pout_key),
    .head_o    (head)
  );

  // Sequencer: load, wait for the pipeline, drain the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_LOAD: begin
          if (in_fire) begin
            if (keep) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_data_i.item_last) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (pout_ctrl.valid && pout_ctrl.last) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (pop) begin
            out_q.sorted_value  <= head.key.value;
            out_q.sorted_last   <= (cnt_q == CNT_W'(1));
            out_q.items_dropped <= ovf_q;
            cnt_q               <= cnt_q - CNT_W'(1);
            if (cnt_q == CNT_W'(1)) begin
              state_q <= ST_LOAD;
              ovf_q   <= 1'b0;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* sv/bse_checker.sv */
// ----------------------------------------------------------------------------
// bse_checker
// Port-level checks of the bucket sort engine, bound to the top level.
// ----------------------------------------------------------------------------
module bse_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input bse_pkg::item_t                in_data_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input bse_pkg::result_t              out_data_o,
  input logic                          cfg_we_i,
  input logic [bse_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic [bse_pkg::VAL_W-1:0]     cfg_wdata_i
);
  import bse_pkg::*;

  logic out_fire;
  assign out_fire = out_valid_o && out_ready_i;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // results within one burst come out in ascending order
  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !out_data_o.sorted_last) ##1 out_fire |->
      $signed(out_data_o.sorted_value) >= $signed($past(out_data_o.sorted_value)))
    else $error("burst not in ascending order");

  // the dropped flag is the same across a burst
  a_drop_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !out_data_o.sorted_last) ##1 out_fire |->
      out_data_o.items_dropped == $past(out_data_o.items_dropped))
    else $error("dropped flag changed within a burst");

  // no new request is taken right after the last one of a set
  a_stop_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.item_last |=> !in_ready_o)
    else $error("request taken right after the last of a set");

  // register writes only while idle, with known index and data
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> in_ready_o && !out_valid_o && !$isunknown({cfg_idx_i, cfg_wdata_i}))
    else $error("register write while busy");

endmodule

bind bucket_sort_engine bse_checker u_bse_checker (.*);
